>>> rtl/irbt_pkg.sv
// Shared constants and types of the IR blob tracker.
package irbt_pkg;

  localparam int BLOB_COUNT = 4;

  localparam int COORD_W = 10;
  localparam int SIZE_W  = 4;
  localparam int SUM_W   = COORD_W + 1;
  localparam int SQ_W    = 2 * COORD_W;
  localparam int SPAN_W  = SQ_W + 1;
  localparam int OFFS_W  = 13;
  localparam int CNT_OUT_W = 3;
  localparam int IDX_W   = $clog2(BLOB_COUNT);
  localparam int CNT_W   = $clog2(BLOB_COUNT + 1);

  localparam logic [COORD_W-1:0] HIDDEN_COORD = 10'd1023;
  localparam logic [SIZE_W-1:0]  HIDDEN_SIZE  = 4'd15;

  localparam logic [COORD_W-1:0] LANDING_X_RST = 10'd512;
  localparam logic [COORD_W-1:0] LANDING_Y_RST = 10'd384;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_LANDING_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LANDING_Y = 2'd1;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } point_t;

  typedef struct packed {
    logic   seen;
    point_t pt;
  } blob_t;

endpackage

>>> rtl/irbt_parser.sv
// Frame byte counter and blob record assembly.
module irbt_parser import irbt_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic [7:0]                   raw_byte_i,
  input  logic                         frame_start_i,
  output blob_t [BLOB_COUNT-1:0]       blobs_o,
  output logic                         last_o
);

  localparam logic [3:0] LAST_POS = 4'(3 * BLOB_COUNT);
  localparam logic [1:0] PH_X_LO  = 2'd0;
  localparam logic [1:0] PH_Y_LO  = 2'd1;
  localparam logic [1:0] PH_PACK  = 2'd2;

  logic [3:0]       pos_q;
  logic [3:0]       pos;
  logic [1:0]       phase_q;
  logic [IDX_W-1:0] slot_q;
  logic             in_record;

  logic [7:0]       x_lo_q;
  logic [7:0]       y_lo_q;
  blob_t [BLOB_COUNT-1:0] blobs_q;

  logic [COORD_W-1:0] new_x;
  logic [COORD_W-1:0] new_y;
  logic [SIZE_W-1:0]  new_size;

  assign pos       = frame_start_i ? 4'd0 : pos_q;
  assign in_record = (pos != 4'd0) && (pos <= LAST_POS);

  assign new_x    = {raw_byte_i[5:4], x_lo_q};
  assign new_y    = {raw_byte_i[7:6], y_lo_q};
  assign new_size = raw_byte_i[3:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= 4'd0;
      phase_q <= PH_X_LO;
      slot_q  <= '0;
    end else if (accept_i) begin
      pos_q <= pos + 4'd1;
      if (pos == 4'd0) begin
        phase_q <= PH_X_LO;
        slot_q  <= '0;
      end else if (in_record) begin
        if (phase_q == PH_PACK) begin
          phase_q <= PH_X_LO;
          slot_q  <= slot_q + IDX_W'(1);
        end else begin
          phase_q <= phase_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && in_record) begin
      case (phase_q)
        PH_X_LO: x_lo_q <= raw_byte_i;
        PH_Y_LO: y_lo_q <= raw_byte_i;
        PH_PACK: begin
          blobs_q[slot_q].pt.x <= new_x;
          blobs_q[slot_q].pt.y <= new_y;
          blobs_q[slot_q].seen <= !((new_x == HIDDEN_COORD) && (new_y == HIDDEN_COORD) &&
                                    (new_size == HIDDEN_SIZE));
        end
        default: ;
      endcase
    end
  end

  assign blobs_o = blobs_q;
  assign last_o  = accept_i && (pos == LAST_POS);

endmodule

>>> rtl/irbt_sq_unit.sv
// Shared squaring unit: registered square of an absolute coordinate difference.
module irbt_sq_unit import irbt_pkg::*; (
  input  logic               clk_i,
  input  logic [COORD_W-1:0] a_i,
  input  logic [COORD_W-1:0] b_i,
  output logic [SQ_W-1:0]    sq_o
);

  logic [COORD_W-1:0] diff;
  logic [SQ_W-1:0]    sq_q;

  assign diff = (a_i > b_i) ? (a_i - b_i) : (b_i - a_i);

  always_ff @(posedge clk_i) begin
    sq_q <= SQ_W'(diff) * SQ_W'(diff);
  end

  assign sq_o = sq_q;

endmodule

>>> rtl/ir_blob_tracker_midpoint.sv
// Top level: position update, farthest-pair walk and result register.
//
//   channel | handshake                | payload
//   --------+--------------------------+---------------------------------------------
//   in      | in_valid_i / in_stall_o  | raw_byte_i, frame_start_i
//   out     | out_valid_o / out_stall_i| midpoint sums, span, count, offsets, single
//   cfg     | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// Bytes are taken while the block is idle. The last record byte starts a position
// update and then a walk over all unordered blob pairs; each pair loads its second blob
// and uses the squaring unit twice (dx then dy) before the compare, and each new row
// first loads its row blob. Input stalls for the update, the whole walk and while the
// result waits for a free output register. Reset puts the remembered positions at the
// default landing point and clears all control state.
module ir_blob_tracker_midpoint import irbt_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [7:0]                 raw_byte_i,
  input  logic                       frame_start_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [SUM_W-1:0]           midpoint_x_sum_o,
  output logic [SUM_W-1:0]           midpoint_y_sum_o,
  output logic [SPAN_W-1:0]          span_squared_o,
  output logic [CNT_OUT_W-1:0]       visible_count_o,
  output logic signed [OFFS_W-1:0]   offset_x_half_o,
  output logic signed [OFFS_W-1:0]   offset_y_half_o,
  output logic                       single_blob_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [COORD_W-1:0]         cfg_data_i
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_UPD  = 3'd1;
  localparam logic [2:0] ST_LDA  = 3'd2;
  localparam logic [2:0] ST_LDB  = 3'd3;
  localparam logic [2:0] ST_DX   = 3'd4;
  localparam logic [2:0] ST_DY   = 3'd5;
  localparam logic [2:0] ST_CMP  = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BLOB_COUNT - 1);
  localparam logic [IDX_W-1:0] LAST_ROW = IDX_W'(BLOB_COUNT - 2);

  logic [2:0]       state_q, state_d;
  logic [IDX_W-1:0] i_q, j_q;
  logic             first_q;
  logic             in_accept;
  logic             last_byte;
  logic             out_free;

  blob_t [BLOB_COUNT-1:0] blobs;
  point_t           rem_q [BLOB_COUNT];
  point_t           rd_pt;
  logic [IDX_W-1:0] rd_addr;
  point_t           a_q, b_q;

  logic [COORD_W-1:0] land_x_q, land_y_q;

  logic [CNT_W-1:0] n_c, count_q;
  point_t           copy_c;

  logic [COORD_W-1:0] unit_a, unit_b;
  logic [SQ_W-1:0]    sq;
  logic [SQ_W-1:0]    acc_q;
  logic [SPAN_W-1:0]  pair_dist;
  logic [SPAN_W-1:0]  best_q;
  logic [SUM_W-1:0]   sx_q, sy_q;

  logic                     out_valid_q;
  logic [SUM_W-1:0]         out_sx_q, out_sy_q;
  logic [SPAN_W-1:0]        out_span_q;
  logic [CNT_OUT_W-1:0]     out_cnt_q;
  logic [OFFS_W-1:0]        out_offx_q, out_offy_q;
  logic                     out_single_q;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;

  irbt_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_accept),
    .raw_byte_i   (raw_byte_i),
    .frame_start_i(frame_start_i),
    .blobs_o      (blobs),
    .last_o       (last_byte)
  );

  // dx in every phase but the dy one
  assign unit_a = (state_q == ST_DY) ? a_q.y : a_q.x;
  assign unit_b = (state_q == ST_DY) ? b_q.y : b_q.x;

  irbt_sq_unit u_sq (
    .clk_i(clk_i),
    .a_i  (unit_a),
    .b_i  (unit_b),
    .sq_o (sq)
  );

  assign pair_dist = SPAN_W'(acc_q) + SPAN_W'(sq);

  assign rd_addr = (state_q == ST_LDA) ? i_q : j_q;
  assign rd_pt   = rem_q[rd_addr];

  // visible count and the visible blob of highest slot
  always_comb begin
    n_c    = '0;
    copy_c = '0;
    for (int k = 0; k < BLOB_COUNT; k++) begin
      if (blobs[k].seen) begin
        n_c    = n_c + CNT_W'(1);
        copy_c = blobs[k].pt;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (last_byte) state_d = ST_UPD;
      ST_UPD:  state_d = ST_LDA;
      ST_LDA:  state_d = ST_LDB;
      ST_LDB:  state_d = ST_DX;
      ST_DX:   state_d = ST_DY;
      ST_DY:   state_d = ST_CMP;
      ST_CMP: begin
        if (j_q != LAST_IDX) begin
          state_d = ST_LDB;
        end else if (i_q == LAST_ROW) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_LDA;
        end
      end
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      i_q      <= '0;
      j_q      <= '0;
      first_q  <= 1'b0;
      land_x_q <= LANDING_X_RST;
      land_y_q <= LANDING_Y_RST;
      for (int k = 0; k < BLOB_COUNT; k++) begin
        rem_q[k].x <= LANDING_X_RST;
        rem_q[k].y <= LANDING_Y_RST;
      end
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == REG_LANDING_X) land_x_q <= cfg_data_i;
        if (cfg_index_i == REG_LANDING_Y) land_y_q <= cfg_data_i;
      end
      if (state_q == ST_UPD) begin
        i_q     <= '0;
        j_q     <= IDX_W'(1);
        first_q <= 1'b1;
        for (int k = 0; k < BLOB_COUNT; k++) begin
          if (blobs[k].seen) begin
            rem_q[k] <= blobs[k].pt;
          end else if (n_c >= CNT_W'(2)) begin
            rem_q[k] <= copy_c;
          end
        end
      end
      if (state_q == ST_CMP) begin
        first_q <= 1'b0;
        if (j_q != LAST_IDX) begin
          j_q <= j_q + IDX_W'(1);
        end else if (i_q != LAST_ROW) begin
          i_q <= i_q + IDX_W'(1);
          j_q <= i_q + IDX_W'(2);
        end
      end
    end
  end

  // pair datapath
  always_ff @(posedge clk_i) begin
    if (state_q == ST_UPD) count_q <= n_c;
    if (state_q == ST_LDA) a_q <= rd_pt;
    if (state_q == ST_LDB) b_q <= rd_pt;
    if (state_q == ST_DY)  acc_q <= sq;
    // first pair always stands; later ones only when strictly farther
    if (state_q == ST_CMP && (first_q || pair_dist > best_q)) begin
      best_q <= pair_dist;
      sx_q   <= SUM_W'(a_q.x) + SUM_W'(b_q.x);
      sy_q   <= SUM_W'(a_q.y) + SUM_W'(b_q.y);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_OUT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT && out_free) begin
      out_sx_q     <= sx_q;
      out_sy_q     <= sy_q;
      out_span_q   <= best_q;
      out_cnt_q    <= CNT_OUT_W'(count_q);
      out_offx_q   <= OFFS_W'(sx_q) + OFFS_W'(2) - OFFS_W'({land_x_q, 1'b0});
      out_offy_q   <= OFFS_W'(sy_q) + OFFS_W'(2) - OFFS_W'({land_y_q, 1'b0});
      out_single_q <= (count_q == CNT_W'(1));
    end
  end

  assign out_valid_o      = out_valid_q;
  assign midpoint_x_sum_o = out_sx_q;
  assign midpoint_y_sum_o = out_sy_q;
  assign span_squared_o   = out_span_q;
  assign visible_count_o  = out_cnt_q;
  assign offset_x_half_o  = out_offx_q;
  assign offset_y_half_o  = out_offy_q;
  assign single_blob_o    = out_single_q;

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP) |-> (j_q > i_q))
    else $error("pair walk visits a pair out of order");

  a_upd_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD) |-> $past(last_byte))
    else $error("position update without a last record byte");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == ST_OUT))
    else $error("result raised outside the result state");

  a_no_walk_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP) |=> !last_byte)
    else $error("byte taken during the pair walk");

endmodule
